// ===== rtl/lfdc_pkg.sv =====
`timescale 1ns / 1ps

package lfdc_pkg;

  // stream and configuration widths
  localparam int IN_W       = 56;
  localparam int OUT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // centroid divider: quotient bits resolved per cycle and number of divider steps
  localparam int QUOT_W     = 10;
  localparam int DIV_BITS   = 5;
  localparam int DIV_STEPS  = QUOT_W / DIV_BITS;
  localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [13:0] DUTY_MAX = 14'h3FFF;

  // sensor weights, sensor 0 first
  localparam logic signed [10:0] WEIGHT [8] = '{
    11'sd334, 11'sd238, 11'sd142, 11'sd48,
    -11'sd48, -11'sd142, -11'sd238, -11'sd334
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SPEED  = 3'd0,
    REG_PICKUP      = 3'd1,
    REG_DARK_LUX    = 3'd2,
    REG_SLOW_LUX    = 3'd3,
    REG_CENTRE_BAND = 3'd4,
    REG_HARD_TURN   = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    NAV_IDLE   = 4'd0,
    NAV_READ   = 4'd1,
    NAV_LEFT   = 4'd2,
    NAV_CENTRE = 4'd3,
    NAV_RIGHT  = 4'd4,
    NAV_LOST   = 4'd5,
    NAV_OBST   = 4'd6,
    NAV_HLEFT  = 4'd7,
    NAV_HRIGHT = 4'd8
  } nav_t;

  typedef enum logic [2:0] {
    GOV_IDLE   = 3'd0,
    GOV_READ   = 3'd1,
    GOV_NORMAL = 3'd2,
    GOV_SLOW   = 3'd3,
    GOV_STOP   = 3'd4
  } gov_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_PICKUP = 2'd1,
    CAUSE_DARK   = 2'd2
  } cause_t;

  typedef enum logic [2:0] {
    MODE_STOP       = 3'd0,
    MODE_FORWARD    = 3'd1,
    MODE_BACKWARD   = 3'd2,
    MODE_SPIN_LEFT  = 3'd3,
    MODE_SPIN_RIGHT = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CL_LOST,
    CL_CENTRE,
    CL_LEFT,
    CL_RIGHT,
    CL_HLEFT,
    CL_HRIGHT
  } line_class_t;

  localparam logic [1:0] FACTOR_ZERO = 2'd0;
  localparam logic [1:0] FACTOR_HALF = 2'd1;
  localparam logic [1:0] FACTOR_FULL = 2'd2;

  localparam logic [3:0] LAMP_BRAKE_L = 4'b0001;
  localparam logic [3:0] LAMP_BRAKE_R = 4'b0010;
  localparam logic [3:0] LAMP_FRONT_L = 4'b0100;
  localparam logic [3:0] LAMP_FRONT_R = 4'b1000;

  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/lfdc_ctrl.sv =====
`timescale 1ns / 1ps

module lfdc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output lfdc_pkg::dp_cmd_t    cmd,
  input  lfdc_pkg::dp_status_t status
);
  import lfdc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (s_tvalid) state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          step <= step + DIV_CNT_W'(1);
          if (step == DIV_CNT_W'(DIV_STEPS - 1)) state <= ST_FINISH;
        end
        ST_FINISH: begin
          // wait for the previous result to leave the output
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE) && !rst;

  always_comb begin
    cmd.load     = s_tvalid && s_tready;
    cmd.div_step = (state == ST_DIVIDE);
    cmd.commit   = (state == ST_FINISH) && status.out_free;
  end

endmodule

// ===== rtl/lfdc_dpath.sv =====
`timescale 1ns / 1ps

module lfdc_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  lfdc_pkg::dp_cmd_t                  cmd,
  output lfdc_pkg::dp_status_t               status,
  input  logic [lfdc_pkg::IN_W-1:0]          s_tdata,
  input  logic                               cfg_we,
  input  logic [lfdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfdc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [lfdc_pkg::OUT_W-1:0]         m_tdata
);
  import lfdc_pkg::*;

  // configuration registers
  logic [13:0]        base_speed;
  logic signed [15:0] pickup_accel_limit;
  logic [16:0]        dark_lux_limit;
  logic [16:0]        slow_lux_limit;
  logic [8:0]         centre_band;
  logic [8:0]         hard_turn_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed         <= 14'd40;
      pickup_accel_limit <= 16'sd18000;
      dark_lux_limit     <= 17'd60;
      slow_lux_limit     <= 17'd200;
      centre_band        <= 9'd48;
      hard_turn_limit    <= 9'd200;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_SPEED:  base_speed         <= cfg_data[13:0];
        REG_PICKUP:      pickup_accel_limit <= signed'(cfg_data[15:0]);
        REG_DARK_LUX:    dark_lux_limit     <= cfg_data[16:0];
        REG_SLOW_LUX:    slow_lux_limit     <= cfg_data[16:0];
        REG_CENTRE_BAND: centre_band        <= cfg_data[8:0];
        REG_HARD_TURN:   hard_turn_limit    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // weighted sum and count of the reflectance bits
  logic signed [10:0] wsum;
  logic [3:0]         bit_cnt;
  logic signed [10:0] wsum_abs;

  always_comb begin
    wsum    = '0;
    bit_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      if (s_tdata[i]) begin
        wsum    = wsum + WEIGHT[i];
        bit_cnt = bit_cnt + 4'd1;
      end
    end
    wsum_abs = wsum[10] ? (11'sd0 - wsum) : wsum;
  end

  // captured tick
  logic               bumped;
  logic               start;
  logic               stop;
  logic [16:0]        lux;
  logic signed [15:0] accel;

  // divider: quo starts as the dividend and fills with quotient bits
  logic [3:0]        div_cnt;
  logic              neg;
  logic [QUOT_W-1:0] quo;
  logic [3:0]        rem;
  logic [QUOT_W-1:0] quo_next;
  logic [3:0]        rem_next;
  logic [4:0]        trial;

  always_comb begin
    quo_next = quo;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial    = {rem_next, quo_next[QUOT_W-1]};
      quo_next = {quo_next[QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, div_cnt}) begin
        trial       = trial - {1'b0, div_cnt};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bumped  <= |(~s_tdata[13:8]);
      start   <= ~s_tdata[14];
      stop    <= ~s_tdata[15];
      lux     <= s_tdata[32:16];
      accel   <= signed'(s_tdata[48:33]);
      div_cnt <= bit_cnt;
      neg     <= wsum[10];
      quo     <= wsum_abs[QUOT_W-1:0];
      rem     <= '0;
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // line class from the truncated centroid magnitude and its sign
  line_class_t line_class;

  always_comb begin
    if (div_cnt == 4'd0) begin
      line_class = CL_LOST;
    end else if (quo <= {1'b0, centre_band}) begin
      line_class = CL_CENTRE;
    end else if (quo <= {1'b0, hard_turn_limit}) begin
      line_class = neg ? CL_RIGHT : CL_LEFT;
    end else begin
      line_class = neg ? CL_HRIGHT : CL_HLEFT;
    end
  end

  // held state
  nav_t        nav;
  gov_t        gov;
  cause_t      cause;
  logic [1:0]  factor;
  mode_t       held_mode;
  logic [13:0] held_left;
  logic [13:0] held_right;
  logic [3:0]  held_lamps;

  nav_t        nav_next;
  gov_t        gov_next;
  cause_t      cause_next;
  logic [1:0]  factor_next;
  mode_t       mode_next;
  logic [13:0] left_next;
  logic [13:0] right_next;
  logic [3:0]  lamps_next;

  always_comb begin
    case (nav)
      NAV_IDLE: nav_next = start ? NAV_READ : NAV_IDLE;
      NAV_READ: begin
        if (stop) begin
          nav_next = NAV_IDLE;
        end else if (bumped) begin
          nav_next = NAV_OBST;
        end else begin
          case (line_class)
            CL_CENTRE: nav_next = NAV_CENTRE;
            CL_LEFT:   nav_next = NAV_LEFT;
            CL_RIGHT:  nav_next = NAV_RIGHT;
            CL_LOST:   nav_next = NAV_LOST;
            CL_HLEFT:  nav_next = NAV_HLEFT;
            default:   nav_next = NAV_HRIGHT;
          endcase
        end
      end
      NAV_LEFT, NAV_CENTRE, NAV_RIGHT, NAV_LOST, NAV_OBST, NAV_HLEFT, NAV_HRIGHT:
        nav_next = NAV_READ;
      default: nav_next = NAV_IDLE;
    endcase
  end

  always_comb begin
    gov_next   = gov;
    cause_next = cause;
    case (gov)
      GOV_IDLE: if (start) gov_next = GOV_READ;
      GOV_READ: begin
        if (accel > pickup_accel_limit) begin
          gov_next   = GOV_STOP;
          cause_next = CAUSE_PICKUP;
        end else if (lux < dark_lux_limit) begin
          gov_next   = GOV_STOP;
          cause_next = CAUSE_DARK;
        end else if (lux < slow_lux_limit) begin
          gov_next = GOV_SLOW;
        end else begin
          gov_next = GOV_NORMAL;
        end
      end
      GOV_NORMAL, GOV_SLOW: gov_next = GOV_READ;
      GOV_STOP: begin
        if (start) begin
          gov_next   = GOV_READ;
          cause_next = CAUSE_NONE;
        end
      end
      default: gov_next = GOV_IDLE;
    endcase
  end

  always_comb begin
    case (gov_next)
      GOV_IDLE, GOV_NORMAL: factor_next = FACTOR_FULL;
      GOV_SLOW:             factor_next = FACTOR_HALF;
      GOV_STOP:             factor_next = FACTOR_ZERO;
      default:              factor_next = factor;
    endcase
  end

  // duties from the speed factor left by the previous tick
  function automatic logic [13:0] sat_duty(input logic [15:0] v);
    return (v > 16'(DUTY_MAX)) ? DUTY_MAX : v[13:0];
  endfunction

  logic [15:0] full;
  logic [17:0] full_x3;
  logic [13:0] duty_half;
  logic [13:0] duty_quarter;
  logic [13:0] duty_3q;

  assign full         = 16'(base_speed) * 16'(factor);
  assign full_x3      = 18'(full) * 18'd3;
  assign duty_half    = sat_duty({1'b0, full[15:1]});
  assign duty_quarter = sat_duty({2'b0, full[15:2]});
  assign duty_3q      = sat_duty(full_x3[17:2]);

  always_comb begin
    mode_next  = held_mode;
    left_next  = held_left;
    right_next = held_right;
    lamps_next = held_lamps;
    case (nav_next)
      NAV_IDLE: begin
        mode_next  = MODE_STOP;
        left_next  = '0;
        right_next = '0;
        lamps_next = '0;
      end
      NAV_LEFT: begin
        mode_next  = MODE_FORWARD;
        left_next  = duty_half;
        right_next = duty_quarter;
        lamps_next = LAMP_BRAKE_L;
      end
      NAV_CENTRE: begin
        mode_next  = MODE_FORWARD;
        left_next  = duty_half;
        right_next = duty_half;
        lamps_next = LAMP_BRAKE_L | LAMP_BRAKE_R;
      end
      NAV_RIGHT: begin
        mode_next  = MODE_FORWARD;
        left_next  = duty_quarter;
        right_next = duty_half;
        lamps_next = LAMP_BRAKE_R;
      end
      NAV_LOST: begin
        mode_next  = MODE_BACKWARD;
        left_next  = duty_half;
        right_next = duty_half;
        lamps_next = LAMP_FRONT_L | LAMP_FRONT_R;
      end
      NAV_OBST: begin
        mode_next  = MODE_STOP;
        left_next  = '0;
        right_next = '0;
        lamps_next = LAMP_BRAKE_L | LAMP_BRAKE_R | LAMP_FRONT_L | LAMP_FRONT_R;
      end
      NAV_HLEFT: begin
        mode_next  = MODE_SPIN_LEFT;
        left_next  = duty_3q;
        right_next = duty_3q;
        lamps_next = LAMP_BRAKE_L;
      end
      NAV_HRIGHT: begin
        mode_next  = MODE_SPIN_RIGHT;
        left_next  = duty_3q;
        right_next = duty_3q;
        lamps_next = LAMP_BRAKE_R;
      end
      default: ;  // read state holds the motor outputs
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nav        <= NAV_IDLE;
      gov        <= GOV_IDLE;
      cause      <= CAUSE_NONE;
      factor     <= FACTOR_FULL;
      held_mode  <= MODE_STOP;
      held_left  <= '0;
      held_right <= '0;
      held_lamps <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        nav        <= nav_next;
        gov        <= gov_next;
        cause      <= cause_next;
        factor     <= factor_next;
        held_mode  <= mode_next;
        held_left  <= left_next;
        held_right <= right_next;
        held_lamps <= lamps_next;
      end
      // held state doubles as the output register
      if (cmd.commit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign status.out_free = !m_tvalid || m_tready;
  assign m_tdata = {4'b0, cause, gov, nav, held_lamps, held_right, held_left, held_mode};

endmodule

// ===== rtl/line_follow_drive_controller.sv =====
`timescale 1ns / 1ps
// channel  signals                      transaction
// s_       s_tvalid s_tready s_tdata    one control tick in
// m_       m_tvalid m_tready m_tdata    one drive result out
// cfg_     cfg_valid cfg_ready          one register write (cfg_index, cfg_data)
//
// a tick is accepted, then the divider resolves five centroid quotient bits per
// step, then the result commits; the next tick is taken right after the commit
// the commit waits while the previous result is still held on m_tdata
// reset is synchronous; s_tready and cfg_ready are low while it is held
// afterwards the block is idle and cfg_ready stays high

module line_follow_drive_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // reflect_bits[7:0], bump_n[13:8], start_button_n[14], stop_button_n[15],
  // ambient_lux[32:16], accel_vertical[48:33], zero pad
  input  logic [lfdc_pkg::IN_W-1:0]         s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // motor_mode[2:0], left_duty[16:3], right_duty[30:17], lamps[34:31],
  // nav_state[38:35], governor_state[41:39], stop_reason[43:42], zero pad
  output logic [lfdc_pkg::OUT_W-1:0]        m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lfdc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = !rst;

  lfdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lfdc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== rtl/lfdc_chk.sv =====
`timescale 1ns / 1ps

module lfdc_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [lfdc_pkg::OUT_W-1:0]        m_tdata
);
  import lfdc_pkg::*;

  // one tick at a time: input closes after each accepted transaction
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a tick is in work");

  // a fresh result shows up only after its tick was accepted, divided and committed
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
    else $error("result without a matching tick");

  // state codes on the output stay within their defined sets
  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= MODE_SPIN_RIGHT) && (m_tdata[38:35] <= NAV_HRIGHT)
                 && (m_tdata[41:39] <= GOV_STOP) && (m_tdata[43:42] <= CAUSE_DARK))
    else $error("undefined code on output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output transaction changed");

endmodule

bind line_follow_drive_controller lfdc_chk u_lfdc_chk (.*);

// ===== tb/line_follow_drive_controller_tb.sv =====
`timescale 1ns / 1ps

module line_follow_drive_controller_tb;
  import lfdc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TICKS_PER_PHASE = 175;
  localparam int unsigned DUTY_CEIL = 16383;
  localparam int LINE_WEIGHT [8] = '{334, 238, 142, 48, -48, -142, -238, -334};

  // one control tick, packed in s_tdata order (lowest field last)
  typedef struct packed {
    logic signed [15:0] accel;
    logic [16:0]        lux;
    logic               stop_n;
    logic               start_n;
    logic [5:0]         bump;
    logic [7:0]         reflect;
  } tick_t;

  typedef struct {
    mode_t       mode;
    logic [13:0] left;
    logic [13:0] right;
    logic [3:0]  lamps;
    nav_t        nav;
    gov_t        gov;
    cause_t      cause;
  } drive_t;

  class drive_scoreboard;
    logic [13:0]        base_speed;
    logic signed [15:0] pickup_limit;
    logic [16:0]        dark_lux;
    logic [16:0]        slow_lux;
    logic [8:0]         centre_band;
    logic [8:0]         hard_turn;

    nav_t       nav;
    gov_t       gov;
    cause_t     halt;
    logic [1:0] factor;
    drive_t     held;

    drive_t expected_drive_q[$];
    int     errors;
    int     results_seen;

    function new();
      base_speed = 14'd40;
      pickup_limit = 16'sd18000;
      dark_lux = 17'd60;
      slow_lux = 17'd200;
      centre_band = 9'd48;
      hard_turn = 9'd200;
      nav = NAV_IDLE;
      gov = GOV_IDLE;
      halt = CAUSE_NONE;
      factor = FACTOR_FULL;
      held.mode = MODE_STOP;
      held.left = '0;
      held.right = '0;
      held.lamps = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_drive_q.size();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [16:0] v);
      case (idx)
        REG_BASE_SPEED:  base_speed = v[13:0];
        REG_PICKUP:      pickup_limit = v[15:0];
        REG_DARK_LUX:    dark_lux = v;
        REG_SLOW_LUX:    slow_lux = v;
        REG_CENTRE_BAND: centre_band = v[8:0];
        REG_HARD_TURN:   hard_turn = v[8:0];
        default: ;
      endcase
    endfunction

    // centroid truncates toward zero; bands tested centre first
    function line_class_t classify(logic [7:0] bits);
      int sum, cnt, c, cb, ht;
      sum = 0;
      cnt = 0;
      cb = int'(centre_band);
      ht = int'(hard_turn);
      for (int i = 0; i < 8; i++) begin
        if (bits[i]) begin
          sum += LINE_WEIGHT[i];
          cnt++;
        end
      end
      if (cnt == 0) return CL_LOST;
      c = sum / cnt;
      if (c <= cb && c >= -cb) return CL_CENTRE;
      if (c <= ht && c > cb) return CL_LEFT;
      if (c >= -ht && c < -cb) return CL_RIGHT;
      if (c > ht) return CL_HLEFT;
      return CL_HRIGHT;
    endfunction

    function logic [13:0] clip(logic [31:0] v);
      return (v > DUTY_CEIL) ? 14'(DUTY_CEIL) : v[13:0];
    endfunction

    function void command(mode_t m, logic [31:0] l, logic [31:0] r, logic [3:0] lamps);
      held.mode = m;
      held.left = clip(l);
      held.right = clip(r);
      held.lamps = lamps;
    endfunction

    function void note_tick(tick_t t);
      line_class_t line;
      logic [5:0]  bumped;
      logic        start_pressed, stop_pressed;
      logic [31:0] full;
      line = classify(t.reflect);
      bumped = ~t.bump;
      start_pressed = !t.start_n;
      stop_pressed = !t.stop_n;
      // duties use the factor left by the previous tick
      full = 32'(base_speed) * 32'(factor);

      case (nav)
        NAV_IDLE: if (start_pressed) nav = NAV_READ;
        NAV_READ: begin
          if (stop_pressed) nav = NAV_IDLE;
          else if (bumped != 0) nav = NAV_OBST;
          else begin
            case (line)
              CL_CENTRE: nav = NAV_CENTRE;
              CL_LEFT:   nav = NAV_LEFT;
              CL_RIGHT:  nav = NAV_RIGHT;
              CL_LOST:   nav = NAV_LOST;
              CL_HLEFT:  nav = NAV_HLEFT;
              default:   nav = NAV_HRIGHT;
            endcase
          end
        end
        NAV_LEFT, NAV_CENTRE, NAV_RIGHT, NAV_LOST, NAV_OBST, NAV_HLEFT, NAV_HRIGHT:
          nav = NAV_READ;
        default: nav = NAV_IDLE;
      endcase

      case (gov)
        GOV_IDLE: if (start_pressed) gov = GOV_READ;
        GOV_READ: begin
          if (t.accel > pickup_limit) begin
            gov = GOV_STOP;
            halt = CAUSE_PICKUP;
          end else if (t.lux < dark_lux) begin
            gov = GOV_STOP;
            halt = CAUSE_DARK;
          end else if (t.lux < slow_lux) gov = GOV_SLOW;
          else gov = GOV_NORMAL;
        end
        GOV_NORMAL, GOV_SLOW: gov = GOV_READ;
        GOV_STOP: begin
          if (start_pressed) begin
            gov = GOV_READ;
            halt = CAUSE_NONE;
          end
        end
        default: gov = GOV_IDLE;
      endcase

      case (nav)
        NAV_IDLE:   command(MODE_STOP, 0, 0, 4'b0000);
        NAV_LEFT:   command(MODE_FORWARD, full / 2, full / 4, LAMP_BRAKE_L);
        NAV_CENTRE: command(MODE_FORWARD, full / 2, full / 2, LAMP_BRAKE_L | LAMP_BRAKE_R);
        NAV_RIGHT:  command(MODE_FORWARD, full / 4, full / 2, LAMP_BRAKE_R);
        NAV_LOST:   command(MODE_BACKWARD, full / 2, full / 2, LAMP_FRONT_L | LAMP_FRONT_R);
        NAV_OBST:   command(MODE_STOP, 0, 0, 4'b1111);
        NAV_HLEFT:  command(MODE_SPIN_LEFT, full * 3 / 4, full * 3 / 4, LAMP_BRAKE_L);
        NAV_HRIGHT: command(MODE_SPIN_RIGHT, full * 3 / 4, full * 3 / 4, LAMP_BRAKE_R);
        default: ;  // read state holds the motor outputs
      endcase

      case (gov)
        GOV_IDLE, GOV_NORMAL: factor = FACTOR_FULL;
        GOV_SLOW:             factor = FACTOR_HALF;
        GOV_STOP:             factor = FACTOR_ZERO;
        default: ;
      endcase

      held.nav = nav;
      held.gov = gov;
      held.cause = halt;
      expected_drive_q.push_back(held);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
    endtask

    task check_drive(logic [OUT_W-1:0] d);
      drive_t e;
      if (expected_drive_q.size() == 0) begin
        report($sformatf("result %0d with no tick pending: %h", results_seen, d));
        results_seen++;
        return;
      end
      e = expected_drive_q.pop_front();
      compare_field("motor_mode", 16'(d[2:0]), 16'(e.mode));
      compare_field("left_duty", 16'(d[16:3]), 16'(e.left));
      compare_field("right_duty", 16'(d[30:17]), 16'(e.right));
      compare_field("lamps", 16'(d[34:31]), 16'(e.lamps));
      compare_field("nav_state", 16'(d[38:35]), 16'(e.nav));
      compare_field("governor_state", 16'(d[41:39]), 16'(e.gov));
      compare_field("stop_reason", 16'(d[43:42]), 16'(e.cause));
      compare_field("pad", 16'(d[OUT_W-1:44]), 16'd0);
      results_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_BASE_SPEED;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drive_scoreboard sb;
  int send_idle = 17;
  int recv_idle = 51;
  int cycle_count = 0;
  logic [16:0] next_cfg [6];

  line_follow_drive_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_drive(m_tdata);
  end

  function automatic tick_t make_tick(logic [7:0] reflect, logic [5:0] bump, logic start_n,
                                      logic stop_n, int lux, int accel);
    tick_t t;
    t.reflect = reflect;
    t.bump = bump;
    t.start_n = start_n;
    t.stop_n = stop_n;
    t.lux = 17'(lux);
    t.accel = 16'(accel);
    return t;
  endfunction

  function automatic int near_limit(int x, int lo, int hi);
    int v;
    v = x + int'($urandom_range(4)) - 2;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // mostly plausible ticks: lux and acceleration are often drawn near the live thresholds
  function automatic tick_t random_tick();
    tick_t t;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) t.reflect = 8'h00;
    else if (pick <= 2) t.reflect = 8'h01 << $urandom_range(7);
    else if (pick == 3) t.reflect = 8'hFF;
    else t.reflect = 8'($urandom);
    t.bump = ($urandom_range(5) == 0) ? 6'($urandom) : 6'h3F;
    t.start_n = ($urandom_range(3) != 0);
    t.stop_n = ($urandom_range(15) != 0);
    case ($urandom_range(4))
      0: t.lux = 17'(near_limit(int'(sb.dark_lux), 0, 131071));
      1: t.lux = 17'(near_limit(int'(sb.slow_lux), 0, 131071));
      2: t.lux = 17'($urandom);
      3: t.lux = 17'($urandom_range(1000));
      default: t.lux = $urandom_range(1) ? 17'h1FFFF : 17'h0;
    endcase
    case ($urandom_range(3))
      0: t.accel = 16'(near_limit(int'(sb.pickup_limit), -32768, 32767));
      1: t.accel = 16'($urandom);
      default: t.accel = 16'(int'($urandom_range(20000)) - 4000);
    endcase
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_W - $bits(tick_t)){1'b0}}, t};
    do @(posedge clk); while (!s_tready);
    sb.note_tick(t);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold off the sender until every tick has produced its result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= next_cfg[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(cfg_reg_t'(i), next_cfg[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ticks at reset settings
    send_tick(make_tick(8'hFF, 6'h3F, 1'b1, 1'b1, 0, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b0, 1'b1, 500, 0));
    send_tick(make_tick(8'h18, 6'h3F, 1'b1, 1'b1, 500, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b1, 1'b1, 500, 0));
    send_tick(make_tick(8'h04, 6'h3F, 1'b1, 1'b1, 100, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b1, 1'b1, 500, 0));
    send_tick(make_tick(8'h01, 6'h3F, 1'b1, 1'b1, 300, 18001));
    send_tick(make_tick(8'h00, 6'h3F, 1'b0, 1'b1, 300, 0));
    send_tick(make_tick(8'h20, 6'h3F, 1'b1, 1'b1, 59, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b0, 1'b1, 500, 0));
    send_tick(make_tick(8'h80, 6'h3F, 1'b1, 1'b1, 131071, 32767));
    send_tick(make_tick(8'h00, 6'h3F, 1'b1, 1'b1, 500, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b1, 1'b1, 500, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b0, 1'b1, 200, -32768));
    send_tick(make_tick(8'h18, 6'h00, 1'b1, 1'b1, 200, 18000));
    send_tick(make_tick(8'h00, 6'h3F, 1'b1, 1'b1, 60, 0));
    // stop beats a bump in the read state
    send_tick(make_tick(8'h18, 6'h3E, 1'b1, 1'b0, 500, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b0, 1'b0, 500, 0));
    send_tick(make_tick(8'hC0, 6'h3F, 1'b1, 1'b1, 199, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b1, 1'b1, 500, 0));
    send_tick(make_tick(8'h0F, 6'h3F, 1'b1, 1'b1, 500, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b1, 1'b1, 500, 0));
    // truncation toward zero on both sides of the centroid
    send_tick(make_tick(8'h19, 6'h3F, 1'b1, 1'b1, 500, 0));
    send_tick(make_tick(8'h00, 6'h3F, 1'b1, 1'b1, 500, 0));
    send_tick(make_tick(8'h98, 6'h3F, 1'b1, 1'b1, 500, 0));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle = 17; recv_idle = 51; end
        1: begin send_idle = 51; recv_idle = 17; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (phase)
        0: next_cfg = '{17'd40, 17'd18000, 17'd60, 17'd200, 17'd48, 17'd200};
        1: next_cfg = '{17'd10000, 17'h07FFF, 17'd0, 17'd0, 17'd0, 17'd0};
        2: next_cfg = '{17'd0, 17'h08000, 17'd131071, 17'd131071, 17'd334, 17'd334};
        // duty saturation, and a centre band wider than the hard turn limit
        3: next_cfg = '{17'd16383, 17'd0, 17'd1000, 17'd50000, 17'd250, 17'd100};
        4: next_cfg = '{17'($urandom_range(10000)), 17'($urandom_range(65535)),
                        17'($urandom_range(2000)), 17'($urandom_range(5000)),
                        17'($urandom_range(334)), 17'($urandom_range(334))};
        default: next_cfg = '{17'd16383, 17'($urandom_range(65535)),
                              17'($urandom_range(131071)), 17'($urandom_range(131071)),
                              17'($urandom_range(334)), 17'($urandom_range(334))};
      endcase
      write_config();
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        send_tick(random_tick());
        if (i % 60 == 59) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
